@@ hdl/mcts_pkg.sv @@
// Shared types, token codes and keyword tables for the token scanner.
package mcts_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int KIND_W   = 5;
  localparam int LINE_W   = 16;
  localparam int SPAN_W   = 24;
  localparam int CH_W     = 8;

  localparam logic [KIND_W-1:0] KIND_INT    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_ID     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_NUM    = 5'd2;
  localparam logic [KIND_W-1:0] KIND_IF     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_ELSE   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_RETURN = 5'd5;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd6;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd10;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd11;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd14;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd15;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_EOF    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_ERR    = 5'd18;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_NUM  = 2'd1,
    PEND_WORD = 2'd2
  } pend_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] length;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } token_pair_t;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    unique case (k)
      2'd0: r = 3'd3;
      2'd1: r = 3'd2;
      2'd2: r = 3'd4;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [1:0] k);
    logic [KIND_W-1:0] r;
    unique case (k)
      2'd0: r = KIND_INT;
      2'd1: r = KIND_IF;
      2'd2: r = KIND_ELSE;
      default: r = KIND_RETURN;
    endcase
    return r;
  endfunction

  function automatic logic [CH_W-1:0] kw_char(input logic [1:0] k, input logic [2:0] at);
    logic [47:0] txt;
    logic [CH_W-1:0] r;
    unique case (k)
      2'd0: txt = {8'h00, 8'h00, 8'h00, "t", "n", "i"};
      2'd1: txt = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
      2'd2: txt = {8'h00, 8'h00, "e", "s", "l", "e"};
      default: txt = {"n", "r", "u", "t", "e", "r"};
    endcase
    unique case (at)
      3'd0: r = txt[7:0];
      3'd1: r = txt[15:8];
      3'd2: r = txt[23:16];
      3'd3: r = txt[31:24];
      3'd4: r = txt[39:32];
      3'd5: r = txt[47:40];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [CH_W-1:0] c,
                                                   output logic hit);
    logic [KIND_W-1:0] r;
    hit = 1'b1;
    unique case (c)
      "=": r = KIND_ASSIGN;
      "+": r = KIND_PLUS;
      "-": r = KIND_MINUS;
      "*": r = KIND_STAR;
      "/": r = KIND_SLASH;
      "(": r = KIND_LPAREN;
      ")": r = KIND_RPAREN;
      "{": r = KIND_LBRACE;
      "}": r = KIND_RBRACE;
      ";": r = KIND_SEMI;
      ">": r = KIND_GT;
      default: begin
        r = KIND_ERR;
        hit = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/mini_c_token_scanner_top.sv @@
// Top level of the token scanner: front end, token queue and output stage.
//
//  channel  dir  tdata                         tuser      tlast
//  s_*      in   [7:0] ch                      [0] opcode -
//  m_*      out  [15:0] line, [39:16] start,   [4:0] kind last result of item
//                [63:40] length
//
// One input transfer per cycle while the queue is not full; a byte that closes a
// token and adds one of its own yields two tokens, which leave one after the other from the output register.
// Each token passes from the input through a queue slot into the output register.
// Reset is synchronous; the queue of four token pairs is empty after it.
// Input stalls only while the queue is full; output stalls back up through it.
module mini_c_token_scanner_top #(
  parameter int OFFSET_BITS = mcts_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = mcts_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // line, text_start, text_length
  output logic [4:0]  m_tuser,   // kind
  output logic        m_tlast
);
  import mcts_pkg::*;

  token_pair_t push_data, head;
  logic        push, pop, full, empty;

  mcts_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (full),
    .q_push  (push),
    .q_data  (push_data)
  );

  mcts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(push_data),
    .pop    (pop),
    .rd_data(head),
    .full   (full),
    .empty  (empty)
  );

  mcts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (empty),
    .q_pop   (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

@@ hdl/mcts_front.sv @@
// Scanner front end: classifies each source byte and queues the tokens it closes.
module mcts_front #(
  parameter int OFFSET_BITS = mcts_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = mcts_pkg::LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output mcts_pkg::token_pair_t q_data
);
  import mcts_pkg::*;

  pend_t                  pend, pend_next;
  logic [3:0]             hits, hits_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [OFFSET_BITS-1:0] tok_len, tok_len_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic                   halted, halted_next;

  logic                   accept;
  logic [CH_W-1:0]        c;
  logic                   is_digit, is_alpha, is_blank, is_nl, is_punct;
  logic [KIND_W-1:0]      p_kind;
  logic [OFFSET_BITS-1:0] offset_inc, tok_len_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [3:0]             hits_adv, hits_new;
  logic [KIND_W-1:0]      flush_kind;
  logic [31:0]            line_w, off_w, start_w, len_w;
  logic [LINE_W-1:0]      line_o;
  logic [SPAN_W-1:0]      off_o, start_o, len_o;
  token_t                 flush_tok, second_tok;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;

  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C)
                    || (c == 8'h0D);
  assign is_nl    = (c == 8'h0A);

  always_comb begin
    p_kind = punct_kind(c, is_punct);
  end

  assign offset_inc  = (offset == '1) ? offset : offset + 1'b1;
  assign tok_len_inc = (tok_len == '1) ? tok_len : tok_len + 1'b1;
  assign line_inc    = (line_cnt == '1) ? line_cnt : line_cnt + 1'b1;

  always_comb begin
    hits_adv   = '0;
    hits_new   = '0;
    flush_kind = KIND_ID;
    for (int k = 0; k < 4; k++) begin
      if (hits[k] && (tok_len < OFFSET_BITS'(kw_len(2'(k))))
          && (kw_char(2'(k), tok_len[2:0]) == c))
        hits_adv[k] = 1'b1;
      if (kw_char(2'(k), 3'd0) == c)
        hits_new[k] = 1'b1;
      if (hits[k] && (tok_len == OFFSET_BITS'(kw_len(2'(k)))))
        flush_kind = kw_kind(2'(k));
    end
  end

  assign line_w  = 32'(line_cnt);
  assign off_w   = 32'(offset);
  assign start_w = 32'(tok_start);
  assign len_w   = 32'(tok_len);
  assign line_o  = (line_w > 32'hFFFF) ? 16'hFFFF : line_w[LINE_W-1:0];
  assign off_o   = (off_w > 32'hFF_FFFF) ? 24'hFF_FFFF : off_w[SPAN_W-1:0];
  assign start_o = (start_w > 32'hFF_FFFF) ? 24'hFF_FFFF : start_w[SPAN_W-1:0];
  assign len_o   = (len_w > 32'hFF_FFFF) ? 24'hFF_FFFF : len_w[SPAN_W-1:0];

  always_comb begin
    flush_tok.kind   = (pend == PEND_NUM) ? KIND_NUM : flush_kind;
    flush_tok.line   = line_o;
    flush_tok.start  = start_o;
    flush_tok.length = len_o;
    second_tok.line  = line_o;
    second_tok.start = off_o;
    if (s_tuser == OP_END) begin
      second_tok.kind   = KIND_EOF;
      second_tok.length = '0;
    end else begin
      second_tok.kind   = is_punct ? p_kind : KIND_ERR;
      second_tok.length = SPAN_W'(1);
    end
  end

  always_comb begin
    logic has_flush, has_second;
    pend_next      = pend;
    hits_next      = hits;
    tok_start_next = tok_start;
    tok_len_next   = tok_len;
    offset_next    = offset;
    line_cnt_next  = line_cnt;
    halted_next    = halted;
    has_flush      = 1'b0;
    has_second     = 1'b0;
    if (accept && !halted) begin
      if (s_tuser == OP_END) begin
        has_flush  = (pend != PEND_NONE);
        has_second = 1'b1;
        pend_next  = PEND_NONE;
        hits_next  = '0;
      end else if ((pend == PEND_WORD) && (is_alpha || is_digit)) begin
        hits_next    = hits_adv;
        tok_len_next = tok_len_inc;
        offset_next  = offset_inc;
      end else if ((pend == PEND_NUM) && is_digit) begin
        tok_len_next = tok_len_inc;
        offset_next  = offset_inc;
      end else begin
        has_flush = (pend != PEND_NONE);
        pend_next = PEND_NONE;
        hits_next = '0;
        if (is_nl) begin
          line_cnt_next = line_inc;
          offset_next   = offset_inc;
        end else if (is_blank) begin
          offset_next = offset_inc;
        end else if (is_digit || is_alpha) begin
          pend_next      = is_digit ? PEND_NUM : PEND_WORD;
          hits_next      = is_digit ? 4'b0000 : hits_new;
          tok_start_next = offset;
          tok_len_next   = OFFSET_BITS'(1);
          offset_next    = offset_inc;
        end else if (is_punct) begin
          has_second  = 1'b1;
          offset_next = offset_inc;
        end else begin
          has_second  = 1'b1;
          halted_next = 1'b1;
        end
      end
    end
    q_push      = has_flush || has_second;
    q_data.two  = has_flush && has_second;
    q_data.tok0 = has_flush ? flush_tok : second_tok;
    q_data.tok1 = second_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= PEND_NONE;
      hits      <= '0;
      tok_start <= '0;
      tok_len   <= '0;
      offset    <= '0;
      line_cnt  <= '0;
      halted    <= 1'b0;
    end else begin
      pend      <= pend_next;
      hits      <= hits_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      offset    <= offset_next;
      line_cnt  <= line_cnt_next;
      halted    <= halted_next;
    end
  end

endmodule

@@ hdl/mcts_queue.sv @@
// Short token-pair queue between the scanner front end and the output stage.
module mcts_queue #(
  parameter int DEPTH = mcts_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mcts_pkg::token_pair_t wr_data,
  input  logic                  pop,
  output mcts_pkg::token_pair_t rd_data,
  output logic                  full,
  output logic                  empty
);
  import mcts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_pair_t       slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/mcts_back.sv @@
// Output stage: serialises queued token pairs into single registered transfers.
module mcts_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mcts_pkg::token_pair_t head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,
  output logic [4:0]            m_tuser,
  output logic                  m_tlast
);
  import mcts_pkg::*;

  logic   sel;
  logic   load, fin;
  token_t chosen, out_tok;

  assign load   = (!m_tvalid || m_tready) && !q_empty;
  assign chosen = sel ? head.tok1 : head.tok0;
  assign fin    = !head.two || sel;
  assign q_pop  = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      sel      <= !fin;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok <= chosen;
      m_tlast <= fin;
    end
  end

  assign m_tdata = {out_tok.length, out_tok.start, out_tok.line};
  assign m_tuser = out_tok.kind;

endmodule

@@ hdl/mcts_checker.sv @@
// Port-level checks for the token scanner, bound to the top level.
module mcts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);
  import mcts_pkg::*;

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= KIND_ERR))
    else $error("token kind out of range");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_EOF)) |-> (m_tdata[63:40] == 24'd0) && m_tlast)
    else $error("eof token with length or not last");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_ERR)) |-> (m_tdata[63:40] == 24'd1) && m_tlast)
    else $error("error token malformed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output transfer changed");

endmodule

bind mini_c_token_scanner_top mcts_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

@@ verif/tb.sv @@
// Self-checking testbench for the mini C token scanner: random and directed source streams.
`timescale 1ns / 100ps

module tb;
  import mcts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic       drain;
    logic       op;
    logic [7:0] ch;
  } src_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] length;
    logic              last;
  } tok_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = OP_CHAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  src_item_t src_items[$];
  tok_rec_t  token_expect[$];
  tok_rec_t  step_toks[$];

  // scanner state as predicted
  pend_t              sc_pend   = PEND_NONE;
  logic [3:0]         sc_hits   = 4'h0;
  logic [SPAN_W-1:0]  sc_start  = '0;
  logic [SPAN_W-1:0]  sc_len    = '0;
  logic [SPAN_W-1:0]  sc_off    = '0;
  logic [LINE_W-1:0]  sc_line   = '0;
  logic               sc_halted = 1'b0;

  int          n_in = 0;
  int          n_out = 0;
  int          n_bad = 0;
  int          idle_cycles = 0;
  logic [31:0] kinds_seen = '0;
  logic [15:0] max_line = '0;
  logic        next_drain = 1'b0;
  logic        calm;
  src_item_t   head;
  tok_rec_t    got;
  tok_rec_t    want;

  mini_c_token_scanner_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  assign calm = (n_in >= 400) && (n_in < 700);

  function automatic string kw_spelling(int k);
    case (k)
      0: return "int";
      1: return "if";
      2: return "else";
      default: return "return";
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] kw_code(int k);
    case (k)
      0: return KIND_INT;
      1: return KIND_IF;
      2: return KIND_ELSE;
      default: return KIND_RETURN;
    endcase
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [KIND_W-1:0] punct_token(logic [7:0] c, output logic hit);
    hit = 1'b1;
    case (c)
      "=": return KIND_ASSIGN;
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      ";": return KIND_SEMI;
      ">": return KIND_GT;
      default: begin
        hit = 1'b0;
        return KIND_ERR;
      end
    endcase
  endfunction

  function automatic logic [3:0] next_hits(logic [3:0] h, logic [SPAN_W-1:0] at,
                                           logic [7:0] c);
    logic [3:0] r;
    string w;
    r = 4'h0;
    for (int k = 0; k < 4; k++) begin
      w = kw_spelling(k);
      if (h[k] && at < w.len() && w[int'(at)] == c) r[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SPAN_W-1:0] sat_span(logic [SPAN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic emit_tok(logic [KIND_W-1:0] kind, logic [SPAN_W-1:0] start,
                          logic [SPAN_W-1:0] length);
    tok_rec_t t;
    t.kind = kind;
    t.line = sc_line;
    t.start = start;
    t.length = length;
    t.last = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endtask

  task automatic flush_pending();
    logic [KIND_W-1:0] kind;
    string w;
    if (sc_pend == PEND_NONE) return;
    if (sc_pend == PEND_NUM) begin
      kind = KIND_NUM;
    end else begin
      kind = KIND_ID;
      for (int k = 0; k < 4; k++) begin
        w = kw_spelling(k);
        if (sc_hits[k] && sc_len == SPAN_W'(w.len())) kind = kw_code(k);
      end
    end
    emit_tok(kind, sc_start, sc_len);
    sc_pend = PEND_NONE;
    sc_hits = 4'h0;
  endtask

  task automatic scan_predict(logic op, logic [7:0] c);
    logic [KIND_W-1:0] pk;
    logic hit;
    tok_rec_t t;
    if (sc_halted) return;
    if (op == OP_END) begin
      flush_pending();
      emit_tok(KIND_EOF, sc_off, '0);
    end else if (sc_pend == PEND_WORD && (is_alpha(c) || is_digit(c))) begin
      sc_hits = next_hits(sc_hits, sc_len, c);
      sc_len = sat_span(sc_len);
      sc_off = sat_span(sc_off);
    end else if (sc_pend == PEND_NUM && is_digit(c)) begin
      sc_len = sat_span(sc_len);
      sc_off = sat_span(sc_off);
    end else begin
      flush_pending();
      pk = punct_token(c, hit);
      if (c == CH_NL) begin
        if (sc_line != '1) sc_line = sc_line + 1'b1;
        sc_off = sat_span(sc_off);
      end else if (is_blank(c)) begin
        sc_off = sat_span(sc_off);
      end else if (is_digit(c) || is_alpha(c)) begin
        sc_pend = is_digit(c) ? PEND_NUM : PEND_WORD;
        sc_hits = is_digit(c) ? 4'h0 : next_hits(4'hf, '0, c);
        sc_start = sc_off;
        sc_len = SPAN_W'(1);
        sc_off = sat_span(sc_off);
      end else if (hit) begin
        emit_tok(pk, sc_off, SPAN_W'(1));
        sc_off = sat_span(sc_off);
      end else begin
        emit_tok(KIND_ERR, sc_off, SPAN_W'(1));
        sc_halted = 1'b1;
      end
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      token_expect.insert(token_expect.size(), t);
    end
    step_toks.delete();
  endtask

  task automatic add_byte(logic [7:0] c);
    src_items.insert(src_items.size(), {next_drain, OP_CHAR, c});
    next_drain = 1'b0;
  endtask

  task automatic add_end();
    src_items.insert(src_items.size(), {next_drain, OP_END, 8'($urandom_range(255))});
    next_drain = 1'b0;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(10))
      0: return "=";
      1: return "+";
      2: return "-";
      3: return "*";
      4: return "/";
      5: return "(";
      6: return ")";
      7: return "{";
      8: return "}";
      9: return ";";
      default: return ">";
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(6))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      4: return CH_NL;
      default: return CH_SP;
    endcase
  endfunction

  // stimulus
  initial begin
    int r;
    int k;
    int cut;
    int up;
    string w;
    logic [7:0] c;
    logic hit;

    add_text("int\tif\nreturn7>x");
    add_end();
    add_text("42");
    add_end();
    add_text("else(");

    next_drain = 1'b1;
    while (src_items.size() < 1290) begin
      if ($urandom_range(199) == 0) next_drain = 1'b1;
      r = $urandom_range(99);
      if (r < 14) begin
        add_text(kw_spelling($urandom_range(3)));
      end else if (r < 24) begin
        k = $urandom_range(3);
        w = kw_spelling(k);
        case ($urandom_range(2))
          0: begin
            cut = $urandom_range(w.len() - 1, 1);
            for (int i = 0; i < cut; i++) add_byte(w[i]);
          end
          1: begin
            add_text(w);
            repeat ($urandom_range(2, 1)) add_byte(rand_alnum());
          end
          default: begin
            up = $urandom_range(w.len() - 1);
            for (int i = 0; i < w.len(); i++) add_byte(i == up ? w[i] ^ 8'h20 : w[i]);
          end
        endcase
      end else if (r < 40) begin
        add_byte($urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25)));
        repeat ($urandom_range(7)) add_byte(rand_alnum());
      end else if (r < 55) begin
        repeat ($urandom_range(6, 1)) add_byte(8'("0" + $urandom_range(9)));
      end else if (r < 75) begin
        add_byte(rand_punct());
      end else if (r < 85) begin
        add_byte(rand_space());
      end else if (r < 90) begin
        add_end();
      end else begin
        do begin
          c = 8'($urandom_range(255));
          void'(punct_token(c, hit));
        end while (!(hit || is_digit(c) || is_alpha(c) || is_blank(c) || c == CH_NL));
        add_byte(c);
      end
      case ($urandom_range(9))
        0, 1, 2, 3: add_byte(rand_space());
        4, 5: add_byte(rand_punct());
        default: ;
      endcase
    end

    next_drain = 1'b1;
    add_text("x=1;");
    add_end();

    next_drain = 1'b1;
    add_text("abc");
    add_byte(8'($urandom_range(255, 128)));
    add_text("ab");
    add_end();
    add_byte(8'($urandom_range(255)));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (src_items.size() != 0 || s_tvalid) @(posedge clk);
    while (token_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d source transfers and %0d checked tokens over %0d token kinds",
             n_in, n_out, $countones(kinds_seen));
    $display("highest line reported %0d; error halt %s", max_line,
             sc_halted ? "reached" : "not reached");
    if (n_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // source driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_predict(s_tuser, s_tdata);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_items.size() != 0) head = src_items[0];
        if (src_items.size() != 0 && !(head.drain && token_expect.size() != 0) &&
            (calm || $urandom_range(99) >= 35)) begin
          head = src_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= head.ch;
          s_tuser <= head.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.line = m_tdata[15:0];
        got.start = m_tdata[39:16];
        got.length = m_tdata[63:40];
        got.last = m_tlast;
        n_out++;
        kinds_seen[m_tuser] = 1'b1;
        if (got.line > max_line) max_line = got.line;
        if (token_expect.size() == 0) begin
          if (n_bad < 10)
            $display("unexpected token: kind %0d line %0d start %0d length %0d last %0b",
                     got.kind, got.line, got.start, got.length, got.last);
          n_bad++;
        end else begin
          want = token_expect.pop_front();
          if (got !== want) begin
            if (n_bad < 10) begin
              $display("token %0d mismatch:", n_out);
              $display("  want kind %0d line %0d start %0d length %0d last %0b",
                       want.kind, want.line, want.start, want.length, want.last);
              $display("  got  kind %0d line %0d start %0d length %0d last %0b",
                       got.kind, got.line, got.start, got.length, got.last);
            end
            n_bad++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
               WATCHDOG_LIMIT, token_expect.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
